@@ src/imt_pkg.sv @@
// ============================================================================
// imt_pkg: shared types and constants for the message line tokenizer
// Byte codes, role codes, scan modes and the result word type.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package imt_pkg;

    localparam int DEFAULT_MAX_PARAM_INDEX = 15;
    localparam int PARAM_NUMBER_W          = 4;
    localparam int ROLE_W                  = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_PREFIX  = 3'd0,
        ROLE_COMMAND = 3'd1,
        ROLE_PARAM   = 3'd2,
        ROLE_TRAIL   = 3'd3,
        ROLE_END     = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        MODE_GAP    = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_TRAIL  = 2'd2,
        MODE_PREFIX = 2'd3
    } scan_mode_t;

    // Token sequencing: command expected, command seen, parameters started.
    typedef enum logic [1:0] {
        TOK_EXPECT_CMD = 2'd0,
        TOK_CMD        = 2'd1,
        TOK_PARAM      = 2'd2
    } tok_role_t;

    typedef struct packed {
        logic [7:0]                out_byte;
        role_t                     role;
        logic [PARAM_NUMBER_W-1:0] param_number;
        logic                      token_start;
        logic                      message_end;
    } result_t;

endpackage : imt_pkg

`default_nettype wire

@@ src/irc_message_tokenizer_unit.sv @@
// ============================================================================
// irc_message_tokenizer_unit: byte-serial chat message line tokenizer
// Tags each non-separator byte with its token role; CR ends the message.
// ============================================================================
//
//   channel | direction | ports                                   | word
//   --------+-----------+-----------------------------------------+----------------
//   s_      | in        | s_valid, s_ready, s_in_byte             | one line byte
//   m_      | out       | m_valid, m_ready, m_out_byte, m_role,   | one tagged byte
//           |           | m_param_number, m_token_start,          | or end marker
//           |           | m_message_end                           |
//
// Cycles: one byte per cycle sustained while m_ready allows; an accepted word reaches m_
//   through the input register, then the classifier into the result register.
// Separator spaces are consumed without producing an output word.
// Reset: synchronous, active low on aresetn; parser returns to line start.
// Stalls: the input register keeps taking words while a result waits, until
//   both registers are full; s_ready then follows m_ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module irc_message_tokenizer_unit
    import imt_pkg::*;
#(
    parameter int MAX_PARAM_INDEX = DEFAULT_MAX_PARAM_INDEX
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_in_byte,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [7:0]                     m_out_byte,
    output logic [ROLE_W-1:0]              m_role,
    output logic [PARAM_NUMBER_W-1:0]      m_param_number,
    output logic                           m_token_start,
    output logic                           m_message_end
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       has_result;
    result_t    parsed;
    logic       can_load;
    logic       consume;
    result_t    out_word;

    // A held byte leaves when it produces nothing or the result register has room.
    assign consume = held_valid && (!has_result || can_load);

    imt_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .consume    (consume),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // Parser state only advances on consume, so a stalled byte is re-evaluated
    // against unchanged state.
    imt_parser #(
        .MAX_PARAM_INDEX (MAX_PARAM_INDEX)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (held_byte),
        .consume    (consume),
        .has_result (has_result),
        .result     (parsed)
    );

    imt_output_stage u_output (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (held_valid && has_result),
        .load_word  (parsed),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .word       (out_word)
    );

    assign m_out_byte     = out_word.out_byte;
    assign m_role         = out_word.role;
    assign m_param_number = out_word.param_number;
    assign m_token_start  = out_word.token_start;
    assign m_message_end  = out_word.message_end;

endmodule : irc_message_tokenizer_unit

`default_nettype wire

@@ src/imt_input_stage.sv @@
// ============================================================================
// imt_input_stage: input byte register
// Holds one accepted byte until the parser consumes it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module imt_input_stage
    import imt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       consume,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Take a new word when empty or when the held one leaves this cycle.
    assign s_ready    = !valid_reg || consume;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_in_byte;
        end
    end

endmodule : imt_input_stage

`default_nettype wire

@@ src/imt_parser.sv @@
// ============================================================================
// imt_parser: tokenizer state and byte classification
// Classifies one byte per cycle and updates the scan state when it is consumed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module imt_parser
    import imt_pkg::*;
#(
    parameter int MAX_PARAM_INDEX = DEFAULT_MAX_PARAM_INDEX
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] in_byte,
    input  wire logic       consume,
    output logic            has_result,
    output result_t         result
);

    localparam logic [PARAM_NUMBER_W-1:0] ParamLimit =
        (MAX_PARAM_INDEX > 15) ? PARAM_NUMBER_W'(15) : PARAM_NUMBER_W'(MAX_PARAM_INDEX);

    scan_mode_t                mode_reg, mode_next;
    logic                      line_start_reg, line_start_next;
    tok_role_t                 tok_reg, tok_next;
    logic [PARAM_NUMBER_W-1:0] pcount_reg, pcount_next;

    logic is_space, is_colon;

    assign is_space = (in_byte == CH_SPACE);
    assign is_colon = (in_byte == CH_COLON);

    always_comb begin
        mode_next                = mode_reg;
        line_start_next          = line_start_reg;
        tok_next                 = tok_reg;
        pcount_next              = pcount_reg;
        has_result               = 1'b0;
        result.out_byte          = in_byte;
        result.role              = ROLE_PREFIX;
        result.param_number      = '0;
        result.token_start       = 1'b0;
        result.message_end       = 1'b0;

        if (in_byte == CH_CR) begin
            has_result          = 1'b1;
            result.role         = ROLE_END;
            result.message_end  = 1'b1;
            mode_next           = MODE_GAP;
            line_start_next     = 1'b1;
            tok_next            = TOK_EXPECT_CMD;
            pcount_next         = '0;
        end else begin
            line_start_next = 1'b0;
            case (mode_reg)
                MODE_TRAIL: begin
                    has_result = 1'b1;
                    if (tok_reg == TOK_CMD) begin
                        result.role = ROLE_COMMAND;
                    end else begin
                        result.role         = ROLE_TRAIL;
                        result.param_number = pcount_reg;
                    end
                end
                MODE_PREFIX: begin
                    if (is_space) begin
                        mode_next = MODE_GAP;
                    end else begin
                        has_result  = 1'b1;
                        result.role = ROLE_PREFIX;
                    end
                end
                MODE_WORD: begin
                    if (is_space) begin
                        mode_next = MODE_GAP;
                    end else begin
                        has_result = 1'b1;
                        if (tok_reg == TOK_CMD) begin
                            result.role = ROLE_COMMAND;
                        end else begin
                            result.role         = ROLE_PARAM;
                            result.param_number = pcount_reg;
                        end
                    end
                end
                default: begin
                    // Between tokens: spaces are dropped, anything else opens a token.
                    if (!is_space) begin
                        has_result         = 1'b1;
                        result.token_start = 1'b1;
                        if (line_start_reg && is_colon) begin
                            mode_next   = MODE_PREFIX;
                            result.role = ROLE_PREFIX;
                        end else begin
                            mode_next = is_colon ? MODE_TRAIL : MODE_WORD;
                            if (tok_reg == TOK_EXPECT_CMD) begin
                                tok_next = TOK_CMD;
                            end else if (tok_reg == TOK_PARAM) begin
                                if (pcount_reg < ParamLimit) begin
                                    pcount_next = pcount_reg + 1'b1;
                                end
                            end else begin
                                tok_next    = TOK_PARAM;
                                pcount_next = '0;
                            end
                            if (tok_next == TOK_CMD) begin
                                result.role = ROLE_COMMAND;
                            end else begin
                                result.role         = is_colon ? ROLE_TRAIL : ROLE_PARAM;
                                result.param_number = pcount_next;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_GAP;
            line_start_reg <= 1'b1;
            tok_reg        <= TOK_EXPECT_CMD;
            pcount_reg     <= '0;
        end else if (consume) begin
            mode_reg       <= mode_next;
            line_start_reg <= line_start_next;
            tok_reg        <= tok_next;
            pcount_reg     <= pcount_next;
        end
    end

endmodule : imt_parser

`default_nettype wire

@@ src/imt_output_stage.sv @@
// ============================================================================
// imt_output_stage: result register
// Holds one result word for the downstream side.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module imt_output_stage
    import imt_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load_valid,
    input  wire result_t       load_word,
    output logic               can_load,
    output logic               m_valid,
    input  wire logic          m_ready,
    output result_t            word
);

    logic    valid_reg;
    result_t word_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign word     = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load_valid) begin
            word_reg <= load_word;
        end
    end

endmodule : imt_output_stage

`default_nettype wire

@@ test/irc_message_tokenizer_unit_tb.sv @@
// ============================================================================
// irc_message_tokenizer_unit_tb: self-checking bench for the line tokenizer
// Feeds directed and random message lines as bytes. A local classifier
// predicts every tagged word, and the monitor checks each output word
// against that prediction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module irc_message_tokenizer_unit_tb;
    import imt_pkg::*;

    localparam int PARAM_TOP      = (DEFAULT_MAX_PARAM_INDEX > (1 << PARAM_NUMBER_W) - 1)
                                    ? (1 << PARAM_NUMBER_W) - 1 : DEFAULT_MAX_PARAM_INDEX;
    localparam int QUIET_LIMIT    = 5000;   // cycles without any handshake
    localparam int STALL_CYCLES   = 90;     // long m_ready hold-off
    localparam int MAX_REPORTS    = 60;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [ROLE_W-1:0]         m_role;
    logic [PARAM_NUMBER_W-1:0] m_param_number;
    logic       m_token_start;
    logic       m_message_end;

    // Pending line bytes and the words they should produce.
    logic [7:0] line_bytes[$];
    result_t    expected_words[$];

    // Idle rates in percent, changed by the sequence between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver stall: sequence bumps the request, monitor counts it down.
    int stall_req  = 0;
    int stall_seen = 0;
    int stall_left = 0;

    int fail_count   = 0;
    int quiet_cycles = 0;
    int pushed_words = 0;   // bytes queued, spaces included

    // Local copy of the parser state.
    scan_mode_t        scan_mode;
    logic              line_start;
    tok_role_t         tok_state;
    logic [PARAM_NUMBER_W-1:0] param_idx;

    irc_message_tokenizer_unit #(
        .MAX_PARAM_INDEX (DEFAULT_MAX_PARAM_INDEX)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_role         (m_role),
        .m_param_number (m_param_number),
        .m_token_start  (m_token_start),
        .m_message_end  (m_message_end)
    );

    always #6 aclk = ~aclk;

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------
    function automatic void parser_clear();
        scan_mode  = MODE_GAP;
        line_start = 1'b1;
        tok_state  = TOK_EXPECT_CMD;
        param_idx  = '0;
    endfunction

    // Classify one accepted byte; queue the word it yields, if any.
    function automatic void classify_byte(input logic [7:0] b);
        result_t r;
        logic    first;
        logic    emit;
        first = line_start;
        emit  = 1'b1;
        r.out_byte     = b;
        r.role         = ROLE_PARAM;
        r.param_number = '0;
        r.token_start  = 1'b0;
        r.message_end  = 1'b0;

        if (b == CH_CR) begin
            // CR always ends the message and rearms the parser
            r.role        = ROLE_END;
            r.message_end = 1'b1;
            parser_clear();
        end else begin
            line_start = 1'b0;
            case (scan_mode)
                MODE_TRAIL: begin
                    // trailing runs to CR, spaces included
                    if (tok_state == TOK_CMD) begin
                        r.role = ROLE_COMMAND;
                    end else begin
                        r.role         = ROLE_TRAIL;
                        r.param_number = param_idx;
                    end
                end
                MODE_PREFIX, MODE_WORD: begin
                    if (b == CH_SPACE) begin
                        scan_mode = MODE_GAP;
                        emit      = 1'b0;
                    end else if (scan_mode == MODE_PREFIX) begin
                        r.role = ROLE_PREFIX;
                    end else if (tok_state == TOK_CMD) begin
                        r.role = ROLE_COMMAND;
                    end else begin
                        r.role         = ROLE_PARAM;
                        r.param_number = param_idx;
                    end
                end
                default: begin
                    r.token_start = 1'b1;
                    if (b == CH_SPACE) begin
                        emit = 1'b0;
                    end else if (first && b == CH_COLON) begin
                        // colon as the very first byte: prefix
                        scan_mode = MODE_PREFIX;
                        r.role    = ROLE_PREFIX;
                    end else begin
                        if (tok_state == TOK_EXPECT_CMD) begin
                            tok_state = TOK_CMD;
                        end else if (tok_state == TOK_PARAM) begin
                            if (param_idx < PARAM_TOP) param_idx = param_idx + 1'b1;
                        end else begin
                            tok_state = TOK_PARAM;
                            param_idx = '0;
                        end
                        scan_mode = (b == CH_COLON) ? MODE_TRAIL : MODE_WORD;
                        // colon token in command position stays a command
                        if (tok_state == TOK_CMD) begin
                            r.role = ROLE_COMMAND;
                        end else begin
                            r.role         = (b == CH_COLON) ? ROLE_TRAIL : ROLE_PARAM;
                            r.param_number = param_idx;
                        end
                    end
                end
            endcase
        end
        if (emit) expected_words = {expected_words, r};
    endfunction

    //------------------------------------------------------------------------
    // Driver: offers queued bytes, holds the word until accepted
    //------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            parser_clear();
        end else begin
            if (s_valid && s_ready) begin
                classify_byte(s_in_byte);
                void'(line_bytes.pop_front());
            end
            // only pick a new word once the current one is gone
            if (!s_valid || s_ready) begin
                if (line_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= line_bytes[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // Monitor: checks each output word, drives m_ready
    //------------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t unexpected word: expected none, actual byte %0d role %0d",
                                 $time, m_out_byte, m_role);
                end else begin
                    check_field("out_byte", expected_words[0].out_byte, m_out_byte);
                    check_field("role", expected_words[0].role, m_role);
                    check_field("param_number", expected_words[0].param_number,
                                m_param_number);
                    check_field("token_start", expected_words[0].token_start, m_token_start);
                    check_field("message_end", expected_words[0].message_end, m_message_end);
                    void'(expected_words.pop_front());
                end
            end
            if (stall_req != stall_seen) begin
                stall_seen <= stall_req;
                stall_left <= STALL_CYCLES;
                m_ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    //------------------------------------------------------------------------
    // Watchdog
    //------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    //------------------------------------------------------------------------
    // Line builders
    //------------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        line_bytes = {line_bytes, b};
        pushed_words++;
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void push_spaces(input int n);
        repeat (n) push_byte(CH_SPACE);
    endfunction

    // Mostly letters, sometimes any byte that is not a separator or marker.
    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
        c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_CR || c == CH_COLON) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void push_word(input int len);
        repeat (len) push_byte(token_char());
    endfunction

    // Random message line: optional prefix, command, params, optional trailing.
    function automatic void add_line();
        int n_par;
        if ($urandom_range(0, 9) == 0) push_spaces($urandom_range(1, 2));
        if ($urandom_range(0, 9) < 4) begin
            push_byte(CH_COLON);
            push_word($urandom_range(0, 6));
            push_spaces($urandom_range(1, 3));
        end
        if ($urandom_range(0, 9) == 0) push_byte(CH_COLON);
        push_word($urandom_range(1, 6));
        // now and then enough params to hit saturation
        n_par = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 4);
        repeat (n_par) begin
            push_spaces($urandom_range(1, 2));
            push_word($urandom_range(1, 5));
        end
        if ($urandom_range(0, 9) < 4) begin
            push_spaces($urandom_range(1, 2));
            push_byte(CH_COLON);
            repeat ($urandom_range(0, 3)) begin
                push_word($urandom_range(0, 4));
                if ($urandom_range(0, 5) == 0) push_byte(CH_COLON);
                push_spaces($urandom_range(0, 2));
            end
        end
        if ($urandom_range(0, 3) == 0) push_spaces($urandom_range(1, 2));
        // occasionally no CR: next line runs on in the same state
        if ($urandom_range(0, 19) != 0) push_byte(CH_CR);
    endfunction

    // Raw noise, rich in separators, colons and CRs.
    function automatic void add_noise();
        int sel;
        repeat ($urandom_range(1, 12)) begin
            sel = $urandom_range(0, 15);
            if (sel < 4)       push_byte(CH_SPACE);
            else if (sel < 6)  push_byte(CH_COLON);
            else if (sel == 6) push_byte(CH_CR);
            else               push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void fill_lines(input int target);
        int start;
        start = pushed_words;
        while (pushed_words - start < target) begin
            if ($urandom_range(0, 99) < 15) add_noise();
            else                            add_line();
        end
    endfunction

    // Hold the sequence back until every queued byte is sent and every expected word is in.
    task automatic wait_drained();
        while (line_bytes.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge aclk);
    endtask

    //------------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 23;
        recv_idle_pct = 80;
        // prefix, command, param, trailing with embedded space
        push_str(":a b c :x y");
        push_byte(CH_CR);
        // leading space then colon: command that runs like a trailing token
        push_str(" :z");
        push_byte(CH_CR);
        // byte extremes and line feed as a plain token byte
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_SPACE);
        push_byte(8'h0A);
        push_byte(CH_CR);
        // colon inside the prefix
        push_str("::");
        push_byte(CH_CR);
        fill_lines(195);
        wait_drained();

        // roles swapped
        send_idle_pct = 80;
        recv_idle_pct = 23;
        fill_lines(205);
        wait_drained();

        // no idling; then a long receiver stall to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_lines(205);
        repeat (25) @(negedge aclk);
        stall_req++;
        wait_drained();

        repeat (12) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : irc_message_tokenizer_unit_tb

`default_nettype wire
